@@ rtl/core/turtle_raster_plotter_defines.svh @@
// Assertion macros shared by the plotter RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TURTLE_RASTER_PLOTTER_DEFINES_SVH
`define TURTLE_RASTER_PLOTTER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define TRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define TRP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TRP_ASSERT(label, prop, msg)
`define TRP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ rtl/core/trp_pkg.sv @@
// Shared types and constants of the turtle raster plotter.
// No dependencies; the interfaces and every RTL module but trp_ram import this package.
`default_nettype none

package trp_pkg;

  // Floor geometry
  localparam int unsigned GRID_ROWS = 32;
  localparam int unsigned GRID_COLS = 64;
  localparam int unsigned ROW_W     = $clog2(GRID_ROWS);
  localparam int unsigned COL_W     = $clog2(GRID_COLS);

  // Fixed field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DIST_W    = 8;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned BITS_W    = 64;

  // Command queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Host command codes; the unused code acts as end
  typedef enum logic [CMD_W-1:0] {
    CMD_PEN_UP     = 3'd0,
    CMD_PEN_DOWN   = 3'd1,
    CMD_TURN_RIGHT = 3'd2,
    CMD_TURN_LEFT  = 3'd3,
    CMD_MOVE       = 3'd4,
    CMD_DISPLAY    = 3'd5,
    CMD_END        = 3'd6
  } cmd_e;

  // Work items that reach the back end
  typedef enum logic [2:0] {
    OP_PEN_UP,
    OP_PEN_DOWN,
    OP_TURN_RIGHT,
    OP_TURN_LEFT,
    OP_MOVE,
    OP_DISPLAY
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DIST_W-1:0] len;
  } op_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_DISP_RD,
    ST_DISP_OUT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/trp_if.sv @@
// Valid/ready channel interfaces of the plotter: commands in, floor rows out.
// Depends on trp_pkg for the field widths.
`default_nettype none

interface trp_cmd_if import trp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DIST_W-1:0] distance;

  modport source (output valid, command, distance, input ready);
  modport sink   (input valid, command, distance, output ready);
endinterface

interface trp_row_if import trp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] row_index;
  logic [BITS_W-1:0]  row_bits;
  logic               last_row;

  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

`default_nettype wire

@@ rtl/core/trp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module trp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/trp_front.sv @@
// Front end: accepts host commands, classifies them and drops no-ops.
// Depends on trp_pkg and trp_cmd_if.
`default_nettype none

module trp_front import trp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  trp_cmd_if.sink   cmd_i,
  output op_t       op_o,
  output logic      op_valid_o,
  input  wire logic op_ready_i
);

  logic valid_q, valid_d;
  op_t  op_q, op_d;
  logic keep;
  logic cmd_xfer;

  // Take a command whenever the stage is empty or drains this cycle
  assign cmd_i.ready = !valid_q || op_ready_i;
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  // Classify: end, the unused code and zero-length moves carry no work
  always_comb begin
    keep    = 1'b1;
    op_d    = op_q;
    op_d.len = cmd_i.distance;
    case (cmd_i.command)
      CMD_PEN_UP:     op_d.op = OP_PEN_UP;
      CMD_PEN_DOWN:   op_d.op = OP_PEN_DOWN;
      CMD_TURN_RIGHT: op_d.op = OP_TURN_RIGHT;
      CMD_TURN_LEFT:  op_d.op = OP_TURN_LEFT;
      CMD_MOVE: begin
        op_d.op = OP_MOVE;
        keep    = (cmd_i.distance != '0);
      end
      CMD_DISPLAY:    op_d.op = OP_DISPLAY;
      default:        keep = 1'b0;
    endcase
  end

  // Hold or replace the classified op
  always_comb begin
    valid_d = valid_q;
    if (cmd_xfer) begin
      valid_d = keep;
    end else if (op_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_xfer && keep) begin
      op_q <= op_d;
    end
  end

  assign op_o       = op_q;
  assign op_valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/trp_queue.sv @@
// Short FIFO of classified ops between the front and back end.
// Depends on trp_pkg and the assertion macros header.
`default_nettype none
`include "turtle_raster_plotter_defines.svh"

module trp_queue import trp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  op_t       push_data_i,
  input  wire logic push_i,
  output logic      push_ready_o,
  output op_t       pop_data_o,
  output logic      pop_valid_o,
  input  wire logic pop_i
);

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TRP_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue occupancy out of range")
  `TRP_ASSERT(a_ptr_track, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue with split pointers")

endmodule

`default_nettype wire

@@ rtl/core/trp_exec.sv @@
// Back end: runs pen, turn, move and display ops against the floor RAM.
// Depends on trp_pkg, trp_row_if, trp_ram and the assertion macros header.
`default_nettype none
`include "turtle_raster_plotter_defines.svh"

module trp_exec import trp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  op_t        op_i,
  input  wire logic  op_valid_i,
  output logic       op_ready_o,
  trp_row_if.source  row_o
);

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  dir_e               heading_q, heading_d;
  logic               pen_q, pen_d;
  logic [DIST_W-1:0]  steps_q, steps_d;
  logic [ROW_W-1:0]   mark_row_q, mark_row_d;
  logic [COL_W-1:0]   mark_col_q, mark_col_d;
  logic [ROW_W-1:0]   disp_cnt_q, disp_cnt_d;
  logic [GRID_ROWS-1:0] row_vld_q, row_vld_d;

  logic               out_valid_q, out_valid_d;
  logic [INDEX_W-1:0] out_index_q;
  logic [BITS_W-1:0]  out_bits_q;
  logic               out_last_q;

  logic               op_xfer;
  logic               out_free;
  logic               out_load;
  logic               disp_last;
  logic               in_disp;
  logic               step_ok;
  logic [ROW_W-1:0]   nxt_row;
  logic [COL_W-1:0]   nxt_col;

  logic               ram_we, ram_re;
  logic [ROW_W-1:0]   ram_waddr, ram_raddr;
  logic [BITS_W-1:0]  ram_wdata, ram_rdata;

  assign op_ready_o = (state_q == ST_IDLE);
  assign op_xfer    = op_valid_i && op_ready_o;
  assign out_free   = !out_valid_q || row_o.ready;
  assign disp_last  = (disp_cnt_q == ROW_W'(GRID_ROWS - 1));
  assign out_load   = (state_q == ST_DISP_OUT) && out_free;
  assign in_disp    = (state_q == ST_DISP_RD) || (state_q == ST_DISP_OUT);

  // Work out one step in the current heading; off-grid steps are skipped
  always_comb begin
    step_ok = 1'b0;
    nxt_row = row_q;
    nxt_col = col_q;
    case (heading_q)
      DIR_NORTH: begin
        step_ok = (row_q != '0);
        nxt_row = row_q - ROW_W'(1);
      end
      DIR_EAST: begin
        step_ok = (col_q != COL_W'(GRID_COLS - 1));
        nxt_col = col_q + COL_W'(1);
      end
      DIR_SOUTH: begin
        step_ok = (row_q != ROW_W'(GRID_ROWS - 1));
        nxt_row = row_q + ROW_W'(1);
      end
      default: begin
        step_ok = (col_q != '0);
        nxt_col = col_q - COL_W'(1);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (op_xfer) begin
          case (op_i.op)
            OP_MOVE:    state_d = (op_i.len != '0) ? ST_STEP : ST_IDLE;
            OP_DISPLAY: state_d = ST_DISP_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        if (step_ok && pen_q) begin
          state_d = ST_MARK;
        end else if (steps_q == DIST_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_MARK:     state_d = (steps_q == '0) ? ST_IDLE : ST_STEP;
      ST_DISP_RD:  state_d = ST_DISP_OUT;
      ST_DISP_OUT: begin
        if (out_free) begin
          state_d = disp_last ? ST_IDLE : ST_DISP_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM controls per state
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    heading_d  = heading_q;
    pen_d      = pen_q;
    steps_d    = steps_q;
    mark_row_d = mark_row_q;
    mark_col_d = mark_col_q;
    disp_cnt_d = disp_cnt_q;
    row_vld_d  = row_vld_q;
    ram_we     = 1'b0;
    ram_waddr  = mark_row_q;
    ram_wdata  = (row_vld_q[mark_row_q] ? ram_rdata : '0) | (BITS_W'(1) << mark_col_q);
    ram_re     = 1'b0;
    ram_raddr  = row_q;
    case (state_q)
      ST_IDLE: begin
        if (op_xfer) begin
          case (op_i.op)
            OP_PEN_UP:     pen_d     = 1'b0;
            OP_PEN_DOWN:   pen_d     = 1'b1;
            OP_TURN_RIGHT: heading_d = dir_e'(heading_q + 2'd1);
            OP_TURN_LEFT:  heading_d = dir_e'(heading_q - 2'd1);
            OP_MOVE:       steps_d   = op_i.len;
            OP_DISPLAY:    disp_cnt_d = '0;
            default:       pen_d     = pen_q;
          endcase
        end
      end
      ST_STEP: begin
        steps_d = steps_q - DIST_W'(1);
        if (step_ok) begin
          row_d = nxt_row;
          col_d = nxt_col;
          if (pen_q) begin
            // Fetch the row of the cell being left
            ram_re     = 1'b1;
            mark_row_d = row_q;
            mark_col_d = col_q;
          end
        end
      end
      ST_MARK: begin
        ram_we                = 1'b1;
        row_vld_d[mark_row_q] = 1'b1;
      end
      ST_DISP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = disp_cnt_q;
      end
      ST_DISP_OUT: begin
        if (out_free && !disp_last) begin
          disp_cnt_d = disp_cnt_q + ROW_W'(1);
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Output register: load a row, drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (row_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      heading_q   <= DIR_SOUTH;
      pen_q       <= 1'b0;
      steps_q     <= '0;
      disp_cnt_q  <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      heading_q   <= heading_d;
      pen_q       <= pen_d;
      steps_q     <= steps_d;
      disp_cnt_q  <= disp_cnt_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_row_q <= mark_row_d;
    mark_col_q <= mark_col_d;
    if (out_load) begin
      out_index_q <= INDEX_W'(disp_cnt_q);
      out_bits_q  <= row_vld_q[disp_cnt_q] ? ram_rdata : '0;
      out_last_q  <= disp_last;
    end
  end

  trp_ram #(
    .WIDTH (BITS_W),
    .DEPTH (GRID_ROWS),
    .AW    (ROW_W)
  ) u_floor (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row_o.valid     = out_valid_q;
  assign row_o.row_index = out_index_q;
  assign row_o.row_bits  = out_bits_q;
  assign row_o.last_row  = out_last_q;

  `TRP_ASSERT(a_mark_needs_pen, (state_q == ST_MARK) |-> pen_q, "mark with pen up")
  `TRP_ASSERT(a_disp_read, (state_q == ST_DISP_OUT) |-> $past(in_disp), "row without a read")

endmodule

`default_nettype wire

@@ rtl/core/turtle_raster_plotter.sv @@
// Top level of the turtle raster plotter: front end, op queue, back end.
// Depends on trp_pkg, trp_if, trp_front, trp_queue and trp_exec.
//
//   channel | dir | payload                         | transfer when
//   cmd_i   | in  | command[2:0], distance[7:0]     | valid && ready
//   row_o   | out | row_index[4:0], row_bits[63:0], | valid && ready
//           |     | last_row                        |
//
// Pen and turn ops finish in the back end's idle state; a move runs a step
// state per step, plus a mark state for a step that marks the floor
// (read-modify-write on the floor RAM); display reads then outputs each of the 32 rows.
// The front stage and queue are registered and absorb up to five
// commands while the back end is busy. Reset clears per-row valid flags, so
// the floor needs no clearing pass. A stalled row output holds the back end.
`default_nettype none

module turtle_raster_plotter import trp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  trp_cmd_if.sink   cmd_i,
  trp_row_if.source row_o
);

  op_t  front_op;
  logic front_valid;
  logic queue_ready;
  op_t  queue_op;
  logic queue_valid;
  logic exec_ready;

  trp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (queue_ready)
  );

  trp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_op),
    .push_i       (front_valid),
    .push_ready_o (queue_ready),
    .pop_data_o   (queue_op),
    .pop_valid_o  (queue_valid),
    .pop_i        (exec_ready)
  );

  trp_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (queue_op),
    .op_valid_i (queue_valid),
    .op_ready_o (exec_ready),
    .row_o      (row_o)
  );

endmodule

`default_nettype wire
